>>> sv/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)

`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> sv/lmim_pkg.sv
// package with widths, codes and shared types of the led matrix index mapper
package lmim_pkg;

  localparam int unsigned CoordInW = 16;
  localparam int unsigned CoordW   = 17;
  localparam int unsigned DistW    = 8;
  localparam int unsigned DirW     = 3;
  localparam int unsigned CntW     = 9;
  localparam int unsigned RemW     = 8;
  localparam int unsigned LinW     = 16;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned LED_COUNT = 256;

  localparam logic [CntW-1:0] RowCountRst    = CntW'(16);
  localparam logic [CntW-1:0] ColumnCountRst = CntW'(16);

  localparam logic [CfgIdxW-1:0] RegRowCount    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegColumnCount = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegLayoutMode  = CfgIdxW'(2);

  localparam logic FuncPlain    = 1'b0;
  localparam logic FuncNeighbor = 1'b1;

  localparam logic [DirW-1:0] DirRight = DirW'(1);
  localparam logic [DirW-1:0] DirLeft  = DirW'(2);
  localparam logic [DirW-1:0] DirDown  = DirW'(3);
  localparam logic [DirW-1:0] DirUp    = DirW'(4);

  typedef enum logic [1:0] {
    LayoutSerpRight = 2'd0,
    LayoutVertSerp  = 2'd1,
    LayoutSerpLeft  = 2'd2,
    LayoutTiled     = 2'd3
  } layout_e;

  typedef struct packed {
    logic              ok;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } coord_t;

  typedef struct packed {
    logic              ok;
    logic [RemW-1:0]   row_rem;
    logic [RemW-1:0]   col_rem;
    logic [CoordW-1:0] row_val;
    logic [CoordW-1:0] col_val;
  } red_t;

  typedef struct packed {
    logic            ok;
    logic [RemW-1:0] r;
    logic [RemW-1:0] c;
  } pos_t;

  // one restoring remainder step, remainder stays below the divisor
  function automatic logic [RemW-1:0] mod_step(input logic [RemW-1:0] rem,
                                               input logic            din,
                                               input logic [CntW-1:0] div);
    logic [RemW:0] t;
    logic [RemW:0] s;
    t = {rem, din};
    s = t - div;
    if (t >= div) begin
      return s[RemW-1:0];
    end
    return t[RemW-1:0];
  endfunction

endpackage

>>> sv/lmim_step.sv
// input stage: applies the neighbor step and checks the matrix edge
module lmim_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lmim_pkg::CntW-1:0]     row_cnt_i,
  input  logic [lmim_pkg::CntW-1:0]     col_cnt_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          func_i,
  input  logic [lmim_pkg::CoordInW-1:0] row_coord_i,
  input  logic [lmim_pkg::CoordInW-1:0] column_coord_i,
  input  logic [lmim_pkg::DirW-1:0]     step_direction_i,
  input  logic [lmim_pkg::DistW-1:0]    step_distance_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output lmim_pkg::coord_t              coord_o
);
  import lmim_pkg::*;

  logic              valid_q;
  coord_t            coord_q;
  coord_t            coord_d;
  logic [CoordW-1:0] row_sum;
  logic [CoordW-1:0] col_sum;
  logic [CoordW-1:0] row_ext;
  logic [CoordW-1:0] col_ext;
  logic [CoordW-1:0] dist_ext;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign coord_o = coord_q;

  always_comb begin
    row_ext  = {1'b0, row_coord_i};
    col_ext  = {1'b0, column_coord_i};
    dist_ext = CoordW'(step_distance_i);
    row_sum  = row_ext + dist_ext;
    col_sum  = col_ext + dist_ext;
    coord_d  = '0;
    case (func_i)
      FuncPlain: begin
        coord_d.ok  = 1'b1;
        coord_d.row = row_ext;
        coord_d.col = col_ext;
      end
      FuncNeighbor: begin
        case (step_direction_i)
          DirRight: begin
            if (col_sum < CoordW'(col_cnt_i)) begin
              coord_d.ok  = 1'b1;
              coord_d.row = row_ext;
              coord_d.col = col_sum;
            end
          end
          DirLeft: begin
            if (col_ext >= dist_ext) begin
              coord_d.ok  = 1'b1;
              coord_d.row = row_ext;
              coord_d.col = col_ext - dist_ext;
            end
          end
          DirDown: begin
            if (row_sum < CoordW'(row_cnt_i)) begin
              coord_d.ok  = 1'b1;
              coord_d.row = row_sum;
              coord_d.col = col_ext;
            end
          end
          DirUp: begin
            if (row_ext >= dist_ext) begin
              coord_d.ok  = 1'b1;
              coord_d.row = row_ext - dist_ext;
              coord_d.col = col_ext;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      coord_q <= coord_d;
    end
  end

endmodule

>>> sv/lmim_reduce.sv
// three stage pipelined modulo of row and column by the matrix size
module lmim_reduce (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lmim_pkg::CntW-1:0] row_cnt_i,
  input  logic [lmim_pkg::CntW-1:0] col_cnt_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  lmim_pkg::coord_t          coord_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output lmim_pkg::pos_t            pos_o
);
  import lmim_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  red_t s1_q, s2_q, s3_q;
  red_t s1_d, s2_d, s3_d;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;

  assign pos_o.ok = s3_q.ok;
  assign pos_o.r  = s3_q.row_rem;
  assign pos_o.c  = s3_q.col_rem;

  // dividend bits 16 down to 11
  always_comb begin
    s1_d         = '0;
    s1_d.ok      = coord_i.ok;
    s1_d.row_val = coord_i.row;
    s1_d.col_val = coord_i.col;
    for (int k = 16; k >= 11; k--) begin
      s1_d.row_rem = mod_step(s1_d.row_rem, coord_i.row[k], row_cnt_i);
      s1_d.col_rem = mod_step(s1_d.col_rem, coord_i.col[k], col_cnt_i);
    end
  end

  // dividend bits 10 down to 5
  always_comb begin
    s2_d = s1_q;
    for (int k = 10; k >= 5; k--) begin
      s2_d.row_rem = mod_step(s2_d.row_rem, s1_q.row_val[k], row_cnt_i);
      s2_d.col_rem = mod_step(s2_d.col_rem, s1_q.col_val[k], col_cnt_i);
    end
  end

  // dividend bits 4 down to 0
  always_comb begin
    s3_d = s2_q;
    for (int k = 4; k >= 0; k--) begin
      s3_d.row_rem = mod_step(s3_d.row_rem, s2_q.row_val[k], row_cnt_i);
      s3_d.col_rem = mod_step(s3_d.col_rem, s2_q.col_val[k], col_cnt_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      s1_q <= s1_d;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

endmodule

>>> sv/lmim_map.sv
// product stage and layout select with the output register
module lmim_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lmim_pkg::CntW-1:0] row_cnt_i,
  input  logic [lmim_pkg::CntW-1:0] col_cnt_i,
  input  lmim_pkg::layout_e         layout_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  lmim_pkg::pos_t            pos_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [lmim_pkg::IdxW-1:0] led_index_o,
  output logic                      index_valid_o
);
  import lmim_pkg::*;

  logic            v1_q, v2_q;
  logic            rdy1, rdy2;
  pos_t            pos_q;
  logic [LinW-1:0] rnc_q;
  logic [IdxW-1:0] cnr_q;
  logic [CoordW-1:0] rnc_full;
  logic [CoordW-1:0] cnr_full;
  logic [LinW-1:0] linear;
  logic            in_range;
  logic [IdxW-1:0] lin8;
  logic [IdxW-1:0] mirror8;
  logic [IdxW-1:0] vert_even;
  logic [IdxW-1:0] vert_odd;
  logic [IdxW-1:0] tile8;
  logic [IdxW-1:0] map8;
  logic [IdxW-1:0] led_index_d;
  logic [IdxW-1:0] led_index_q;
  logic            index_valid_q;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;

  assign led_index_o   = led_index_q;
  assign index_valid_o = index_valid_q;

  assign rnc_full = CoordW'(pos_i.r) * CoordW'(col_cnt_i);
  assign cnr_full = CoordW'(pos_i.c) * CoordW'(row_cnt_i);

  always_comb begin
    linear    = rnc_q + LinW'(pos_q.c);
    in_range  = {1'b0, linear} < CoordW'(LED_COUNT);
    lin8      = rnc_q[IdxW-1:0] + pos_q.c;
    mirror8   = rnc_q[IdxW-1:0] + col_cnt_i[IdxW-1:0] - pos_q.c - IdxW'(1);
    vert_even = cnr_q + row_cnt_i[IdxW-1:0] - pos_q.r - IdxW'(1);
    vert_odd  = cnr_q + pos_q.r;
    tile8     = {|pos_q.r[7:3], |pos_q.c[7:3], pos_q.r[2:0],
                 pos_q.r[0] ? ~pos_q.c[2:0] : pos_q.c[2:0]};
    case (layout_i)
      LayoutSerpRight: map8 = pos_q.r[0] ? mirror8 : lin8;
      LayoutVertSerp:  map8 = pos_q.r[0] ? vert_odd : vert_even;
      LayoutSerpLeft:  map8 = pos_q.r[0] ? lin8 : mirror8;
      LayoutTiled:     map8 = tile8;
      default:         map8 = '0;
    endcase
    led_index_d = (pos_q.ok && in_range) ? map8 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      pos_q <= pos_i;
      rnc_q <= rnc_full[LinW-1:0];
      cnr_q <= cnr_full[IdxW-1:0];
    end
    if (rdy2 && v1_q) begin
      led_index_q   <= led_index_d;
      index_valid_q <= pos_q.ok;
    end
  end

endmodule

>>> sv/led_matrix_index_mapper_core.sv
// top level of the led matrix index mapper with configuration registers
// Maps a row and column (or a neighbor reached by a step in one of four directions) to the
// strip index of an LED for one of four wiring layouts. One lookup is accepted every clock unless
// the output stalls and the pipeline fills. Each lookup passes through registered stages: the step
// and edge check, the row and column modulo reduction (a restoring remainder unit handling about six
// dividend bits per stage), the row and column products, and the layout select, which is also the
// output register. Configuration writes take effect at once; the user must make them while no
// lookup is in flight, as the block itself does not enforce this.
`include "assert_macros.svh"

module led_matrix_index_mapper_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lmim_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lmim_pkg::CntW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [lmim_pkg::CoordInW-1:0] row_coord_i,
  input  logic [lmim_pkg::CoordInW-1:0] column_coord_i,
  input  logic [lmim_pkg::DirW-1:0]     step_direction_i,
  input  logic [lmim_pkg::DistW-1:0]    step_distance_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lmim_pkg::IdxW-1:0]     led_index_o,
  output logic                          index_valid_o
);
  import lmim_pkg::*;

  logic [CntW-1:0] row_count_q;
  logic [CntW-1:0] column_count_q;
  logic [1:0]      layout_mode_q;
  logic [CntW-1:0] row_cnt;
  logic [CntW-1:0] col_cnt;
  layout_e         layout;

  logic   step_valid, step_ready;
  coord_t step_coord;
  logic   red_valid, red_ready;
  pos_t   red_pos;

  // a zero count acts as one
  assign row_cnt = (row_count_q == '0) ? CntW'(1) : row_count_q;
  assign col_cnt = (column_count_q == '0) ? CntW'(1) : column_count_q;
  assign layout  = layout_e'(layout_mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= RowCountRst;
      column_count_q <= ColumnCountRst;
      layout_mode_q  <= LayoutSerpRight;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegRowCount:    row_count_q    <= cfg_data_i;
        RegColumnCount: column_count_q <= cfg_data_i;
        RegLayoutMode:  layout_mode_q  <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  lmim_step u_step (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .row_cnt_i        (row_cnt),
    .col_cnt_i        (col_cnt),
    .valid_i          (in_valid_i),
    .ready_o          (in_ready_o),
    .func_i           (func_i),
    .row_coord_i      (row_coord_i),
    .column_coord_i   (column_coord_i),
    .step_direction_i (step_direction_i),
    .step_distance_i  (step_distance_i),
    .valid_o          (step_valid),
    .ready_i          (step_ready),
    .coord_o          (step_coord)
  );

  lmim_reduce u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .row_cnt_i (row_cnt),
    .col_cnt_i (col_cnt),
    .valid_i   (step_valid),
    .ready_o   (step_ready),
    .coord_i   (step_coord),
    .valid_o   (red_valid),
    .ready_i   (red_ready),
    .pos_o     (red_pos)
  );

  lmim_map u_map (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_cnt_i     (row_cnt),
    .col_cnt_i     (col_cnt),
    .layout_i      (layout),
    .valid_i       (red_valid),
    .ready_o       (red_ready),
    .pos_i         (red_pos),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .led_index_o   (led_index_o),
    .index_valid_o (index_valid_o)
  );

  // input held back only when every stage is full and the output is stalled
  `ASSERT_IMPLIES(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  // an off-edge neighbor never carries an index
  `ASSERT_IMPLIES(a_invalid_zero, clk_i, rst_ni, out_valid_o && !index_valid_o, led_index_o == '0)
  // reduced coordinates stay below the matrix size
  `ASSERT_IMPLIES(a_rem_in_range, clk_i, rst_ni, red_valid, (CntW'(red_pos.r) < row_cnt) && (CntW'(red_pos.c) < col_cnt))

endmodule

>>> tb/sv/tb_led_matrix_index_mapper_core.sv
`timescale 1ns / 100ps
// testbench for the led matrix index mapper: directed and random lookups checked against a predictor
module tb_led_matrix_index_mapper_core;
  import lmim_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned SegmentLen  = 40;
  localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(3);

  typedef struct packed {
    logic [IdxW-1:0] led_index;
    logic            index_valid;
  } strip_result_t;

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CntW-1:0]     cfg_data_i       = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic                func_i           = FuncPlain;
  logic [CoordInW-1:0] row_coord_i      = '0;
  logic [CoordInW-1:0] column_coord_i   = '0;
  logic [DirW-1:0]     step_direction_i = '0;
  logic [DistW-1:0]    step_distance_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [IdxW-1:0]     led_index_o;
  logic                index_valid_o;

  logic [CntW-1:0] rows_cfg   = RowCountRst;
  logic [CntW-1:0] cols_cfg   = ColumnCountRst;
  layout_e         layout_cfg = LayoutSerpRight;

  strip_result_t pending_lookups[$];
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   error_count   = 0;
  int unsigned   checked_count = 0;
  int unsigned   config_count  = 0;
  int unsigned   cycle_count   = 0;

  led_matrix_index_mapper_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .row_coord_i      (row_coord_i),
    .column_coord_i   (column_coord_i),
    .step_direction_i (step_direction_i),
    .step_distance_i  (step_distance_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .led_index_o      (led_index_o),
    .index_valid_o    (index_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_count(logic [CntW-1:0] cnt);
    return (cnt == '0) ? 1 : int'(cnt);
  endfunction

  function automatic logic [IdxW-1:0] map_strip_index(int unsigned row, int unsigned col);
    int unsigned nr;
    int unsigned nc;
    int unsigned r;
    int unsigned c;
    int unsigned linear;
    int unsigned base;
    int unsigned v;
    nr = eff_count(rows_cfg);
    nc = eff_count(cols_cfg);
    r = row % nr;
    c = col % nc;
    linear = r * nc + c;
    if (linear >= LED_COUNT) begin
      return '0;
    end
    case (layout_cfg)
      LayoutSerpRight: v = r[0] ? r * nc + nc - c - 1 : linear;
      LayoutVertSerp:  v = r[0] ? c * nr + r : (c + 1) * nr - r - 1;
      LayoutSerpLeft:  v = r[0] ? linear : r * nc + nc - c - 1;
      default: begin
        base = (r > 7 ? 128 : 0) + (c > 7 ? 64 : 0) + (r % 8) * 8;
        v = r[0] ? base + 7 - (c % 8) : base + (c % 8);
      end
    endcase
    return v[IdxW-1:0];
  endfunction

  function automatic strip_result_t predict_lookup(logic f, logic [CoordInW-1:0] row,
                                                   logic [CoordInW-1:0] col,
                                                   logic [DirW-1:0] dir,
                                                   logic [DistW-1:0] step_len);
    strip_result_t res;
    int unsigned   r;
    int unsigned   c;
    int unsigned   n;
    r = row;
    c = col;
    n = step_len;
    res = '0;
    if (f == FuncPlain) begin
      res.led_index = map_strip_index(r, c);
      res.index_valid = 1'b1;
    end else begin
      case (dir)
        DirRight: res.index_valid = (c + n < eff_count(cols_cfg));
        DirLeft:  res.index_valid = (c >= n);
        DirDown:  res.index_valid = (r + n < eff_count(rows_cfg));
        DirUp:    res.index_valid = (r >= n);
        default:  res.index_valid = 1'b0;
      endcase
      if (res.index_valid) begin
        case (dir)
          DirRight: res.led_index = map_strip_index(r, c + n);
          DirLeft:  res.led_index = map_strip_index(r, c - n);
          DirDown:  res.led_index = map_strip_index(r + n, c);
          default:  res.led_index = map_strip_index(r - n, c);
        endcase
      end
    end
    return res;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    strip_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_lookups.size() == 0) begin
        $error("result transfer with no lookup outstanding: led_index %0d index_valid %0b",
               led_index_o, index_valid_o);
        error_count++;
      end else begin
        exp_res = pending_lookups.pop_front();
        checked_count++;
        if (led_index_o !== exp_res.led_index) begin
          $error("led_index: expected %0d, got %0d", exp_res.led_index, led_index_o);
          error_count++;
        end
        if (index_valid_o !== exp_res.index_valid) begin
          $error("index_valid: expected %0b, got %0b", exp_res.index_valid, index_valid_o);
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_lookup(logic f, logic [CoordInW-1:0] row, logic [CoordInW-1:0] col,
                             logic [DirW-1:0] dir, logic [DistW-1:0] step_len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= f;
    row_coord_i      <= row;
    column_coord_i   <= col;
    step_direction_i <= dir;
    step_distance_i  <= step_len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_lookups.push_back(predict_lookup(f, row, col, dir, step_len));
  endtask

  // hold off new lookups until every result has come back
  task automatic drain_lookups();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_registers(int unsigned rows, int unsigned cols, layout_e mode);
    logic [CfgIdxW-1:0] reg_sel [4];
    logic [CntW-1:0]    reg_val [4];
    reg_sel[0] = RegRowCount;
    reg_sel[1] = RegColumnCount;
    reg_sel[2] = RegLayoutMode;
    reg_sel[3] = RegSpare;
    reg_val[0] = CntW'(rows);
    reg_val[1] = CntW'(cols);
    reg_val[2] = {7'($urandom), mode};
    reg_val[3] = CntW'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= reg_sel[i];
      cfg_data_i  <= reg_val[i];
      @(posedge clk_i);
      case (reg_sel[i])
        RegRowCount:    rows_cfg = reg_val[i];
        RegColumnCount: cols_cfg = reg_val[i];
        RegLayoutMode:  layout_cfg = layout_e'(reg_val[i][1:0]);
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    config_count++;
  endtask

  task automatic test_plain_lookup();
    send_lookup(FuncPlain, 16'd0, 16'd0, 3'($urandom), 8'($urandom));
    send_lookup(FuncPlain, 16'd1, 16'd0, DirRight, 8'd255);
    send_lookup(FuncPlain, 16'd15, 16'd15, DirUp, 8'd0);
    send_lookup(FuncPlain, 16'hFFFF, 16'hFFFF, 3'd7, 8'hFF);
    send_lookup(FuncPlain, 16'd16, 16'd17, 3'd0, 8'd1);
    drain_lookups();
  endtask

  task automatic test_layouts();
    layout_e mode;
    for (int m = 0; m < 4; m++) begin
      mode = layout_e'(m);
      write_registers(16, 16, mode);
      send_lookup(FuncPlain, 16'd1, 16'd3, 3'd0, 8'd0);
      send_lookup(FuncPlain, 16'd10, 16'd9, 3'd0, 8'd0);
      drain_lookups();
    end
    // zero row count acts as one row
    write_registers(0, 256, LayoutSerpRight);
    send_lookup(FuncPlain, 16'd7, 16'd300, 3'd0, 8'd0);
    drain_lookups();
    // mapped value above eight bits
    write_registers(200, 2, LayoutVertSerp);
    send_lookup(FuncPlain, 16'd0, 16'd1, 3'd0, 8'd0);
    drain_lookups();
    // position beyond the strip length
    write_registers(256, 256, LayoutSerpLeft);
    send_lookup(FuncPlain, 16'd3, 16'd5, 3'd0, 8'd0);
    drain_lookups();
  endtask

  task automatic test_neighbors();
    write_registers(10, 12, LayoutSerpLeft);
    send_lookup(FuncNeighbor, 16'd2, 16'd5, DirRight, 8'd6);
    send_lookup(FuncNeighbor, 16'd2, 16'd5, DirRight, 8'd7);
    send_lookup(FuncNeighbor, 16'd4, 16'd3, DirLeft, 8'd3);
    send_lookup(FuncNeighbor, 16'd4, 16'd3, DirLeft, 8'd4);
    send_lookup(FuncNeighbor, 16'd4, 16'hFFFF, DirLeft, 8'd0);
    send_lookup(FuncNeighbor, 16'd9, 16'd1, DirDown, 8'd0);
    send_lookup(FuncNeighbor, 16'd9, 16'd1, DirDown, 8'd1);
    send_lookup(FuncNeighbor, 16'hFFFF, 16'd6, DirUp, 8'd255);
    send_lookup(FuncNeighbor, 16'd3, 16'd3, 3'd0, 8'd1);
    send_lookup(FuncNeighbor, 16'd3, 16'd3, 3'd7, 8'd1);
    drain_lookups();
  endtask

  function automatic int unsigned pick_count();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 256;
      3:       return $urandom_range(1, 256);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  task automatic send_random_lookup();
    logic [CoordInW-1:0] row;
    logic [CoordInW-1:0] col;
    logic [DirW-1:0]     dir;
    logic [DistW-1:0]    step_len;
    row = ($urandom_range(0, 3) == 0) ? CoordInW'($urandom)
                                      : CoordInW'($urandom_range(0, eff_count(rows_cfg) + 3));
    col = ($urandom_range(0, 3) == 0) ? CoordInW'($urandom)
                                      : CoordInW'($urandom_range(0, eff_count(cols_cfg) + 3));
    dir = ($urandom_range(0, 9) == 0) ? DirW'($urandom) : DirW'($urandom_range(1, 4));
    step_len = ($urandom_range(0, 4) == 0) ? DistW'($urandom) : DistW'($urandom_range(0, 8));
    send_lookup(1'($urandom), row, col, dir, step_len);
  endtask

  task automatic test_random_lookups();
    int unsigned send_pct [3];
    int unsigned recv_pct [3];
    send_pct = '{20, 84, 0};
    recv_pct = '{84, 20, 0};
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      for (int s = 0; s < RandomItems / (3 * SegmentLen); s++) begin
        write_registers(pick_count(), pick_count(), layout_e'($urandom_range(0, 3)));
        for (int i = 0; i < SegmentLen; i++) begin
          send_random_lookup();
        end
        drain_lookups();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_lookup();
    test_layouts();
    test_neighbors();
    test_random_lookups();
    drain_lookups();
    $display("checked %0d lookup results over %0d register settings", checked_count,
             config_count);
    $display("covered all four layouts, plain and neighbor lookups, and sender/receiver stalls");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> led_matrix_index_mapper_core.f
+incdir+sv
sv/lmim_pkg.sv
sv/lmim_step.sv
sv/lmim_reduce.sv
sv/lmim_map.sv
sv/led_matrix_index_mapper_core.sv
tb/sv/tb_led_matrix_index_mapper_core.sv
